### src/mss_pkg.sv
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants of the marker stream splitter
// Marker tables, UTF-8 lead decoding, stream modes, sequencer states and
// the structs passed between the sequencer, the hold chain and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

   // hold chain sizing
   localparam int HOLD_DEPTH = 16;
   localparam int HOLD_CNT_W = $clog2(HOLD_DEPTH + 1);

   // marker lengths and the index width of the marker tables
   localparam int THINK_LEN  = 8;
   localparam int TOOL_LEN   = 11;
   localparam int MARK_IDX_W = 4;

   // utf-8 tail bookkeeping
   localparam int TAIL_W = 3;

   // byte classes
   localparam logic [7:0] MARK_LT   = 8'h3C;
   localparam logic [7:0] CONT_MASK = 8'hC0;
   localparam logic [7:0] CONT_TAG  = 8'h80;
   localparam logic [7:0] LEAD3_MIN = 8'd224;
   localparam logic [7:0] LEAD4_MIN = 8'd240;

   typedef enum logic [1:0] {
      MODE_CONTENT = 2'd0,
      MODE_REASON  = 2'd1,
      MODE_STOP    = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEED,
      ST_FEED2,
      ST_LEAD,
      ST_REL,
      ST_MARK,
      ST_CHUNK,
      ST_CLOSE
   } seq_state_type;

   // hold chain control: shift toward the head or write one cell
   typedef struct packed {
      logic                  shift;
      logic                  append;
      logic [HOLD_CNT_W-1:0] wr_pos;
      logic [7:0]            wr_byte;
   } hold_ctl_type;

   // one result beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       channel;
      logic       delta_end;
   } rsp_item_type;

   // marker character at a position, reasoning marker or tool-call marker
   function automatic logic [7:0] mark_char(input logic reason,
                                            input logic [MARK_IDX_W-1:0] idx);
      logic [7:0] c;
      c = 8'h00;
      if (reason) begin
         case (idx)
            4'd0:    c = 8'h3C;
            4'd1:    c = 8'h2F;
            4'd2:    c = 8'h74;
            4'd3:    c = 8'h68;
            4'd4:    c = 8'h69;
            4'd5:    c = 8'h6E;
            4'd6:    c = 8'h6B;
            4'd7:    c = 8'h3E;
            default: c = 8'h00;
         endcase
      end else begin
         case (idx)
            4'd0:    c = 8'h3C;
            4'd1:    c = 8'h74;
            4'd2:    c = 8'h6F;
            4'd3:    c = 8'h6F;
            4'd4:    c = 8'h6C;
            4'd5:    c = 8'h5F;
            4'd6:    c = 8'h63;
            4'd7:    c = 8'h61;
            4'd8:    c = 8'h6C;
            4'd9:    c = 8'h6C;
            4'd10:   c = 8'h3E;
            default: c = 8'h00;
         endcase
      end
      return c;
   endfunction

   // sequence length announced by a utf-8 lead byte
   function automatic logic [TAIL_W-1:0] lead_width(input logic [7:0] b);
      logic [TAIL_W-1:0] w;
      if (b < CONT_TAG) begin
         w = TAIL_W'(1);
      end else if (b < LEAD3_MIN) begin
         w = TAIL_W'(2);
      end else if (b < LEAD4_MIN) begin
         w = TAIL_W'(3);
      end else begin
         w = TAIL_W'(4);
      end
      return w;
   endfunction

endpackage

`default_nettype wire

### src/marker_stream_splitter.sv
// ----------------------------------------------------------------------------
// marker_stream_splitter: splits a text byte stream into reasoning and content
// Top level: configuration register port, byte sequencer, hold chain and the
// result register.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one text byte per beat (or an empty chunk end), with chunk_end
//            on the last beat of a chunk and final_flush on a final chunk.
//   rsp_*  : released bytes tagged content or reasoning, close-only beats that
//            end a delta, and rsp_last on the last result of each input beat.
//   csr_*  : write start_in_reasoning while the block is idle; this clears
//            all held bytes and flags and starts a new stream.
// Sequence
//   A beat's byte either goes straight out or is held. Held bytes are released
//   one per cycle while the result register can drain, as the hold chain shifts
//   one cell toward its head; a new byte after such a release takes a further
//   step. A chunk end adds a close step, a final flush releases held bytes
//   first, and a marker hit passes through a release step and then closes.
//   The last result of a beat stays pending; it goes out with rsp_last in the
//   cycle the next beat is accepted or in the next idle cycle.
// Reset and stall
//   Reset empties the hold chain and selects content mode. A stalled rsp
//   channel holds its beat; the sequencer keeps one result pending and
//   pauses until the result register drains.
// ----------------------------------------------------------------------------
`default_nettype none

module marker_stream_splitter (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_byte_valid,
   input  wire logic       req_chunk_end,
   input  wire logic       req_final_flush,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_has_byte,
   output logic            rsp_channel,
   output logic            rsp_delta_end,
   output logic            rsp_last,
   input  wire logic       csr_valid,
   output logic            csr_ready,
   input  wire logic       csr_start_in_reasoning
);

   import mss_pkg::*;

   hold_ctl_type hold_ctl;
   rsp_item_type push_item;
   logic [7:0]   head_byte;
   logic         push;
   logic         push_last;
   logic         out_free;
   logic         cfg_wr;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_item_type rsp_item_ff, rsp_item_in;
   logic         rsp_last_ff, rsp_last_in;

   // register writes are always taken
   assign csr_ready = 1'b1;
   assign cfg_wr    = csr_valid && csr_ready;

   assign out_free = !rsp_valid_ff || rsp_ready;

   mss_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_data_byte   (req_data_byte),
      .req_byte_valid  (req_byte_valid),
      .req_chunk_end   (req_chunk_end),
      .req_final_flush (req_final_flush),
      .cfg_wr          (cfg_wr),
      .cfg_reason      (csr_start_in_reasoning),
      .head_byte       (head_byte),
      .out_free        (out_free),
      .hold_ctl        (hold_ctl),
      .push            (push),
      .push_item       (push_item),
      .push_last       (push_last)
   );

   mss_hold_chain u_chain (
      .clock     (clock),
      .hold_ctl  (hold_ctl),
      .head_byte (head_byte)
   );

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_item_in  = rsp_item_ff;
      rsp_last_in  = rsp_last_ff;
      if (push) begin
         rsp_valid_in = 1'b1;
         rsp_item_in  = push_item;
         rsp_last_in  = push_last;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_byte  = rsp_item_ff.out_byte;
   assign rsp_has_byte  = rsp_item_ff.has_byte;
   assign rsp_channel   = rsp_item_ff.channel;
   assign rsp_delta_end = rsp_item_ff.delta_end;
   assign rsp_last      = rsp_last_ff;

endmodule

`default_nettype wire

### src/mss_cell.sv
// ----------------------------------------------------------------------------
// mss_cell: one byte cell of the hold chain
// Loads a new byte when written, otherwise takes its neighbor's byte on shift.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_cell (
   input  wire logic       clock,
   input  wire logic       shift,
   input  wire logic       load,
   input  wire logic [7:0] load_byte,
   input  wire logic [7:0] next_byte,
   output logic [7:0]      cell_byte
);

   logic [7:0] cell_ff;
   logic [7:0] cell_in;

   // write wins, shift pulls the byte behind this cell forward
   always_comb begin
      cell_in = cell_ff;
      if (load) begin
         cell_in = load_byte;
      end else if (shift) begin
         cell_in = next_byte;
      end
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign cell_byte = cell_ff;

endmodule

`default_nettype wire

### src/mss_hold_chain.sv
// ----------------------------------------------------------------------------
// mss_hold_chain: row of held-byte cells
// Cell 0 is the oldest held byte. Appends write the cell at the fill
// position, releases shift the whole row one cell toward the head.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_hold_chain (
   input  wire logic                 clock,
   input  wire mss_pkg::hold_ctl_type hold_ctl,
   output logic [7:0]                head_byte
);

   import mss_pkg::*;

   logic [7:0] cell_q [HOLD_DEPTH];

   // the row of cells, each fed by its neighbor behind it
   for (genvar i = 0; i < HOLD_DEPTH; i++) begin : g_cell
      logic [7:0] next_byte;
      logic       load;

      if (i == HOLD_DEPTH - 1) begin : g_tail
         assign next_byte = 8'h00;
      end else begin : g_mid
         assign next_byte = cell_q[i+1];
      end

      assign load = hold_ctl.append && (hold_ctl.wr_pos == HOLD_CNT_W'(i));

      mss_cell u_cell (
         .clock     (clock),
         .shift     (hold_ctl.shift),
         .load      (load),
         .load_byte (hold_ctl.wr_byte),
         .next_byte (next_byte),
         .cell_byte (cell_q[i])
      );
   end

   assign head_byte = cell_q[0];

endmodule

`default_nettype wire

### src/mss_ctrl.sv
// ----------------------------------------------------------------------------
// mss_ctrl: byte sequencer of the marker stream splitter
// Takes one input beat, runs marker matching and utf-8 holding on it, drives
// the hold chain and, while the pending slot can drain, produces one result per
// cycle into that slot so that the last result of a beat can be flagged.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic [7:0]           req_data_byte,
   input  wire logic                 req_byte_valid,
   input  wire logic                 req_chunk_end,
   input  wire logic                 req_final_flush,
   input  wire logic                 cfg_wr,
   input  wire logic                 cfg_reason,
   input  wire logic [7:0]           head_byte,
   input  wire logic                 out_free,
   output mss_pkg::hold_ctl_type     hold_ctl,
   output logic                      push,
   output mss_pkg::rsp_item_type     push_item,
   output logic                      push_last
);

   import mss_pkg::*;

   seq_state_type         state_ff, state_in;
   seq_state_type         ret_ff, ret_in;
   mode_type              mode_ff, mode_in;
   logic [7:0]            b_ff, b_in;
   logic                  ce_ff, ce_in;
   logic                  fl_ff, fl_in;
   logic [HOLD_CNT_W-1:0] hold_cnt_ff, hold_cnt_in;
   logic [HOLD_CNT_W-1:0] rel_left_ff, rel_left_in;
   logic [TAIL_W-1:0]     tail_len_ff, tail_len_in;
   logic [TAIL_W-1:0]     tail_width_ff, tail_width_in;
   logic                  prior_ff, prior_in;
   logic                  delta_open_ff, delta_open_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_item_type          pend_ff, pend_in;

   logic                  go;
   logic                  reason;
   logic [HOLD_CNT_W-1:0] m;
   logic [HOLD_CNT_W-1:0] mlen;
   logic                  match;
   logic                  is_cont;
   logic [TAIL_W-1:0]     tail_nx;
   seq_state_type         done_st;
   logic                  do_f2, do_lead, do_close;
   logic                  em, em_has, em_dend;
   logic [7:0]            em_byte;

   // marker progress and byte classes
   assign reason  = (mode_ff == MODE_REASON);
   assign m       = hold_cnt_ff - HOLD_CNT_W'(tail_len_ff);
   assign mlen    = reason ? HOLD_CNT_W'(THINK_LEN) : HOLD_CNT_W'(TOOL_LEN);
   assign match   = (m < mlen) && (b_ff == mark_char(reason, m[MARK_IDX_W-1:0]));
   assign is_cont = ((b_ff & CONT_MASK) == CONT_TAG);
   assign tail_nx = tail_len_ff + TAIL_W'(1);
   assign done_st = ce_ff ? ST_CHUNK : ST_IDLE;

   // a working step may produce a result only if the pending slot can drain
   assign go = !pend_valid_ff || out_free;

   // next state and datapath control
   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      mode_in       = mode_ff;
      b_in          = b_ff;
      ce_in         = ce_ff;
      fl_in         = fl_ff;
      hold_cnt_in   = hold_cnt_ff;
      rel_left_in   = rel_left_ff;
      tail_len_in   = tail_len_ff;
      tail_width_in = tail_width_ff;
      prior_in      = prior_ff;
      delta_open_in = delta_open_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;

      hold_ctl         = '0;
      hold_ctl.wr_pos  = hold_cnt_ff;
      hold_ctl.wr_byte = b_ff;

      em        = 1'b0;
      em_byte   = 8'h00;
      em_has    = 1'b0;
      em_dend   = 1'b0;
      do_f2     = 1'b0;
      do_lead   = 1'b0;
      do_close  = 1'b0;
      push      = 1'b0;
      push_item = pend_ff;
      push_last = 1'b0;
      req_ready = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            // drain the previous beat's last result while taking a new beat
            req_ready = !pend_valid_ff || out_free;
            if (pend_valid_ff && out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
            end
            if (req_valid && req_ready) begin
               b_in  = req_data_byte;
               ce_in = req_chunk_end;
               fl_in = req_final_flush;
               if (mode_ff != MODE_STOP) begin
                  if (req_byte_valid) begin
                     state_in = ST_FEED;
                  end else if (req_chunk_end) begin
                     state_in = ST_CHUNK;
                  end
               end
            end
         end

         ST_FEED: begin
            if (go) begin
               if (match) begin
                  hold_ctl.append = 1'b1;
                  hold_cnt_in     = hold_cnt_ff + HOLD_CNT_W'(1);
                  if (m + HOLD_CNT_W'(1) == mlen) begin
                     rel_left_in = HOLD_CNT_W'(tail_len_ff);
                     ret_in      = ST_MARK;
                     state_in    = ST_REL;
                  end else begin
                     state_in = done_st;
                  end
               end else if (m != '0) begin
                  // partial marker broken: everything held goes out first
                  rel_left_in = hold_cnt_ff;
                  ret_in      = ST_FEED2;
                  state_in    = ST_REL;
               end else begin
                  do_f2 = 1'b1;
               end
            end
         end

         ST_FEED2: begin
            if (go) begin
               do_f2 = 1'b1;
            end
         end

         ST_LEAD: begin
            if (go) begin
               do_lead = 1'b1;
            end
         end

         ST_REL: begin
            // release one held byte per cycle from the head of the chain, while the pending slot can drain
            if (go) begin
               if (rel_left_ff == '0) begin
                  state_in = ret_ff;
               end else begin
                  em             = 1'b1;
                  em_byte        = head_byte;
                  em_has         = 1'b1;
                  hold_ctl.shift = 1'b1;
                  hold_cnt_in    = hold_cnt_ff - HOLD_CNT_W'(1);
                  tail_len_in    = (tail_len_ff != '0) ? tail_len_ff - TAIL_W'(1) : '0;
                  prior_in       = 1'b1;
                  rel_left_in    = rel_left_ff - HOLD_CNT_W'(1);
                  if (rel_left_ff == HOLD_CNT_W'(1)) begin
                     state_in = ret_ff;
                  end
               end
            end
         end

         ST_MARK: begin
            // marker complete: close, drop marker bytes, switch mode
            if (go) begin
               do_close    = 1'b1;
               hold_cnt_in = '0;
               tail_len_in = '0;
               prior_in    = 1'b0;
               if (reason) begin
                  mode_in  = MODE_CONTENT;
                  state_in = ce_ff ? ST_CHUNK : ST_IDLE;
               end else begin
                  mode_in  = MODE_STOP;
                  state_in = ST_IDLE;
               end
            end
         end

         ST_CHUNK: begin
            if (go) begin
               if (fl_ff && (hold_cnt_ff != '0)) begin
                  rel_left_in = hold_cnt_ff;
                  ret_in      = ST_CLOSE;
                  state_in    = ST_REL;
               end else begin
                  do_close = 1'b1;
                  prior_in = 1'b0;
                  if (fl_ff) begin
                     tail_len_in = '0;
                  end
                  state_in = ST_IDLE;
               end
            end
         end

         ST_CLOSE: begin
            if (go) begin
               do_close    = 1'b1;
               prior_in    = 1'b0;
               tail_len_in = '0;
               state_in    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // byte handling once no partial marker is pending
      if (do_f2) begin
         if (b_ff == MARK_LT) begin
            hold_ctl.append = 1'b1;
            hold_cnt_in     = hold_cnt_ff + HOLD_CNT_W'(1);
            state_in        = done_st;
         end else if (is_cont) begin
            if (tail_len_ff != '0) begin
               hold_ctl.append = 1'b1;
               hold_cnt_in     = hold_cnt_ff + HOLD_CNT_W'(1);
               tail_len_in     = tail_nx;
               if (tail_nx >= tail_width_ff) begin
                  rel_left_in = hold_cnt_ff + HOLD_CNT_W'(1);
                  ret_in      = done_st;
                  state_in    = ST_REL;
               end else begin
                  state_in = done_st;
               end
            end else if (prior_ff) begin
               // stray continuation joins the run already released
               em       = 1'b1;
               em_byte  = b_ff;
               em_has   = 1'b1;
               state_in = done_st;
            end else begin
               // stray continuation opening a segment: held as a two-byte lead
               hold_ctl.append = 1'b1;
               hold_cnt_in     = hold_cnt_ff + HOLD_CNT_W'(1);
               tail_len_in     = TAIL_W'(1);
               tail_width_in   = TAIL_W'(2);
               state_in        = done_st;
            end
         end else if (tail_len_ff != '0) begin
            rel_left_in = HOLD_CNT_W'(tail_len_ff);
            ret_in      = ST_LEAD;
            state_in    = ST_REL;
         end else begin
            do_lead = 1'b1;
         end
      end

      // ascii goes straight out, a multi-byte lead starts a new tail
      if (do_lead) begin
         if (b_ff < CONT_TAG) begin
            em       = 1'b1;
            em_byte  = b_ff;
            em_has   = 1'b1;
            prior_in = 1'b1;
         end else begin
            hold_ctl.append = 1'b1;
            hold_cnt_in     = hold_cnt_ff + HOLD_CNT_W'(1);
            tail_len_in     = TAIL_W'(1);
            tail_width_in   = lead_width(b_ff);
         end
         state_in = done_st;
      end

      // close-only beat for an open delta
      if (do_close) begin
         if (delta_open_ff) begin
            em      = 1'b1;
            em_dend = 1'b1;
         end
         delta_open_in = 1'b0;
      end

      // new result goes to the pending slot, the older one moves out
      if (em) begin
         if (pend_valid_ff) begin
            push      = 1'b1;
            push_item = pend_ff;
            push_last = 1'b0;
         end
         pend_valid_in     = 1'b1;
         pend_in.out_byte  = em_byte;
         pend_in.has_byte  = em_has;
         pend_in.channel   = reason;
         pend_in.delta_end = em_dend;
         if (em_has) begin
            delta_open_in = 1'b1;
         end
      end

      // register write starts a new stream
      if (cfg_wr) begin
         state_in      = ST_IDLE;
         mode_in       = cfg_reason ? MODE_REASON : MODE_CONTENT;
         hold_cnt_in   = '0;
         tail_len_in   = '0;
         tail_width_in = TAIL_W'(1);
         prior_in      = 1'b0;
         delta_open_in = 1'b0;
         pend_valid_in = 1'b0;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         ret_ff        <= ST_IDLE;
         mode_ff       <= MODE_CONTENT;
         hold_cnt_ff   <= '0;
         rel_left_ff   <= '0;
         tail_len_ff   <= '0;
         tail_width_ff <= TAIL_W'(1);
         prior_ff      <= 1'b0;
         delta_open_ff <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         ret_ff        <= ret_in;
         mode_ff       <= mode_in;
         hold_cnt_ff   <= hold_cnt_in;
         rel_left_ff   <= rel_left_in;
         tail_len_ff   <= tail_len_in;
         tail_width_ff <= tail_width_in;
         prior_ff      <= prior_in;
         delta_open_ff <= delta_open_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // beat payload
   always_ff @(posedge clock) begin
      b_ff    <= b_in;
      ce_ff   <= ce_in;
      fl_ff   <= fl_in;
      pend_ff <= pend_in;
   end

`ifndef SYNTHESIS
   // the utf-8 tail always sits inside the held bytes
   assert property (@(posedge clock) disable iff (reset)
      HOLD_CNT_W'(tail_len_ff) <= hold_cnt_ff)
      else $error("utf-8 tail longer than held bytes");

   // the chain is never written and shifted in the same cycle
   assert property (@(posedge clock) disable iff (reset)
      !(hold_ctl.append && hold_ctl.shift))
      else $error("hold chain append and shift collide");

   // a release never asks for more bytes than are held
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_REL) |-> (rel_left_ff <= hold_cnt_ff))
      else $error("release count exceeds hold count");

   // once stopped the sequencer rests
   assert property (@(posedge clock) disable iff (reset)
      (mode_ff == MODE_STOP) |-> (state_ff == ST_IDLE))
      else $error("sequencer busy in stopped mode");
`endif

endmodule

`default_nettype wire

### verif/marker_stream_splitter_tb.sv
// ----------------------------------------------------------------------------
// marker_stream_splitter_tb: self-checking bench for the marker stream splitter
// Drives text bytes in chunks, with think and tool-call markers, utf-8
// sequences and final flushes, through directed cases and random streams.
// An in-bench predictor of the splitter works out every released beat, and
// each rsp beat is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module marker_stream_splitter_tb;
   import mss_pkg::*;

   localparam int MAX_RESULTS  = 16;
   localparam int RANDOM_BEATS = 115;
   localparam int SETTLE_CYC   = 40;
   localparam int STUCK_LIMIT  = 1000;
   localparam logic [8*THINK_LEN-1:0] THINK_TEXT = "</think>";
   localparam logic [8*TOOL_LEN-1:0]  TOOL_TEXT  = {"<tool", "_call>"};

   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic       channel;
      logic       delta_end;
      logic       last;
   } split_beat_type;

   logic       clock                  = 1'b0;
   logic       reset                  = 1'b1;
   logic       req_valid              = 1'b0;
   logic       req_ready;
   logic [7:0] req_data_byte          = 8'h00;
   logic       req_byte_valid         = 1'b0;
   logic       req_chunk_end          = 1'b0;
   logic       req_final_flush        = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready              = 1'b1;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic       rsp_channel;
   logic       rsp_delta_end;
   logic       rsp_last;
   logic       csr_valid              = 1'b0;
   logic       csr_ready;
   logic       csr_start_in_reasoning = 1'b0;

   // predictor state
   logic [7:0]     held_bytes[$];
   int             tail_len;
   int             tail_width;
   bit             prior_out;
   bit             delta_open;
   mode_type       split_mode;
   split_beat_type step_beats[$];
   split_beat_type owed_beats[$];

   int fail_count   = 0;
   int live_beats   = 0;
   int stuck_cycles = 0;
   bit gaps_on      = 1'b1;

   marker_stream_splitter DUT (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_ready              (req_ready),
      .req_data_byte          (req_data_byte),
      .req_byte_valid         (req_byte_valid),
      .req_chunk_end          (req_chunk_end),
      .req_final_flush        (req_final_flush),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_out_byte           (rsp_out_byte),
      .rsp_has_byte           (rsp_has_byte),
      .rsp_channel            (rsp_channel),
      .rsp_delta_end          (rsp_delta_end),
      .rsp_last               (rsp_last),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_start_in_reasoning (csr_start_in_reasoning)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // ------------------------------------------------------------------------
   // predictor
   // ------------------------------------------------------------------------

   function automatic logic [7:0] mark_byte(bit reason, int idx);
      if (reason) return THINK_TEXT[8*(THINK_LEN-1-idx) +: 8];
      return TOOL_TEXT[8*(TOOL_LEN-1-idx) +: 8];
   endfunction

   function automatic int mark_len(bit reason);
      return reason ? THINK_LEN : TOOL_LEN;
   endfunction

   // byte count of the utf-8 sequence a lead byte opens
   function automatic int utf_width(logic [7:0] b);
      if (b < CONT_TAG) return 1;
      if (b < LEAD3_MIN) return 2;
      if (b < LEAD4_MIN) return 3;
      return 4;
   endfunction

   function automatic void restart_stream(bit reason);
      held_bytes.delete();
      tail_len   = 0;
      tail_width = 1;
      prior_out  = 1'b0;
      delta_open = 1'b0;
      split_mode = reason ? MODE_REASON : MODE_CONTENT;
   endfunction

   function automatic void emit_beat(logic [7:0] b, bit has, bit close);
      split_beat_type beat;
      if (step_beats.size() >= MAX_RESULTS) return;
      beat = '{out_byte: b, has_byte: has,
               channel: (split_mode == MODE_REASON),
               delta_end: close, last: 1'b0};
      step_beats.insert(step_beats.size(), beat);
      if (has) delta_open = 1'b1;
   endfunction

   function automatic void close_delta();
      if (delta_open) begin
         emit_beat(8'h00, 1'b0, 1'b1);
         delta_open = 1'b0;
      end
   endfunction

   // release the oldest k held bytes
   function automatic void release_held(int k);
      if (k > held_bytes.size()) k = held_bytes.size();
      if (k == 0) return;
      repeat (k) emit_beat(held_bytes.pop_front(), 1'b1, 1'b0);
      tail_len  = (tail_len > k) ? tail_len - k : 0;
      prior_out = 1'b1;
   endfunction

   function automatic void hold_byte(logic [7:0] b);
      if (held_bytes.size() >= HOLD_DEPTH) release_held(1);
      held_bytes.insert(held_bytes.size(), b);
   endfunction

   function automatic void feed_byte(logic [7:0] b);
      bit reason;
      int mlen;
      int m;
      reason = (split_mode == MODE_REASON);
      mlen   = mark_len(reason);
      m      = held_bytes.size() - tail_len;

      // marker match continues
      if (m < mlen && b == mark_byte(reason, m)) begin
         hold_byte(b);
         if (m + 1 == mlen) begin
            release_held(tail_len);
            close_delta();
            held_bytes.delete();
            tail_len   = 0;
            prior_out  = 1'b0;
            split_mode = reason ? MODE_CONTENT : MODE_STOP;
         end
         return;
      end
      // broken partial marker goes out
      if (m > 0) begin
         release_held(held_bytes.size());
         tail_len = 0;
      end
      if (b == mark_byte(reason, 0)) begin
         hold_byte(b);
         return;
      end
      // continuation byte
      if ((b & CONT_MASK) == CONT_TAG) begin
         if (tail_len > 0) begin
            hold_byte(b);
            tail_len++;
            if (tail_len >= tail_width) release_held(held_bytes.size());
         end else if (prior_out) begin
            emit_beat(b, 1'b1, 1'b0);
         end else begin
            hold_byte(b);
            tail_len   = 1;
            tail_width = 2;
         end
         return;
      end
      // ascii or a new lead byte
      release_held(tail_len);
      if (utf_width(b) == 1) begin
         emit_beat(b, 1'b1, 1'b0);
         prior_out = 1'b1;
      end else begin
         hold_byte(b);
         tail_len   = 1;
         tail_width = utf_width(b);
      end
   endfunction

   function automatic void split_step(bit bv, logic [7:0] b, bit ce, bit ff);
      step_beats.delete();
      if (split_mode == MODE_STOP) return;
      if (bv) feed_byte(b);
      if (ce && split_mode != MODE_STOP) begin
         if (ff) begin
            release_held(held_bytes.size());
            held_bytes.delete();
            tail_len = 0;
         end
         close_delta();
         prior_out = 1'b0;
      end
      if (step_beats.size() > 0) step_beats[step_beats.size()-1].last = 1'b1;
      foreach (step_beats[i]) owed_beats.insert(owed_beats.size(), step_beats[i]);
   endfunction

   // ------------------------------------------------------------------------
   // rsp checking and watchdog
   // ------------------------------------------------------------------------

   function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, actual %0h", name, want, got);
         fail_count++;
      end
   endfunction

   split_beat_type want_beat;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (owed_beats.size() == 0) begin
            $error("rsp beat with none expected: out_byte %0h", rsp_out_byte);
            fail_count++;
         end else begin
            want_beat = owed_beats.pop_front();
            check_field("out_byte", want_beat.out_byte, rsp_out_byte);
            check_field("has_byte", 8'(want_beat.has_byte), 8'(rsp_has_byte));
            check_field("channel", 8'(want_beat.channel), 8'(rsp_channel));
            check_field("delta_end", 8'(want_beat.delta_end), 8'(rsp_delta_end));
            check_field("last", 8'(want_beat.last), 8'(rsp_last));
         end
      end
   end

   // cycles with no beat on any channel
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("== FAIL ==");
            $finish;
         end
      end
   end

   // rsp back-pressure in short bursts
   initial begin
      int stall;
      stall = 0;
      forever begin
         @(negedge clock);
         if (stall > 0) begin
            rsp_ready = 1'b0;
            stall--;
         end else if (gaps_on && $urandom_range(0, 4) == 0) begin
            rsp_ready = 1'b0;
            stall = $urandom_range(0, 2);
         end else begin
            rsp_ready = 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // request side
   // ------------------------------------------------------------------------

   task automatic req_gap(int n);
      repeat (n) begin
         @(negedge clock);
         req_valid = 1'b0;
      end
   endtask

   task automatic send_beat(bit bv, logic [7:0] b, bit ce, bit ff);
      if (gaps_on && $urandom_range(0, 3) == 0) req_gap($urandom_range(1, 3));
      @(negedge clock);
      req_valid       = 1'b1;
      req_data_byte   = b;
      req_byte_valid  = bv;
      req_chunk_end   = ce;
      req_final_flush = ff;
      do @(posedge clock); while (!req_ready);
      if (split_mode != MODE_STOP && (bv || ce)) live_beats++;
      split_step(bv, b, ce, ff);
   endtask

   task automatic send_text(string s, bit ce_last, bit ff_last);
      for (int i = 0; i < s.len(); i++)
         send_beat(1'b1, s[i], ce_last && i == s.len() - 1, ff_last && i == s.len() - 1);
   endtask

   // hold off until every owed beat is back
   task automatic drain_results();
      req_gap(1);
      while (owed_beats.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(bit reason);
      drain_results();
      repeat (SETTLE_CYC) @(posedge clock);
      @(negedge clock);
      csr_valid              = 1'b1;
      csr_start_in_reasoning = reason;
      do @(posedge clock); while (!csr_ready);
      restart_stream(reason);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // tests
   // ------------------------------------------------------------------------

   // reasoning stream, think marker split across a chunk end
   task automatic test_reason_to_content();
      csr_write(1'b1);
      send_text("a</th", 1'b1, 1'b0);
      send_text("ink>", 1'b0, 1'b0);
   endtask

   // utf-8 tails, stray continuations, empty chunks, byte extremes
   task automatic test_utf8_edges();
      send_beat(1'b1, 8'hE2, 1'b0, 1'b0);
      send_beat(1'b1, 8'h82, 1'b1, 1'b0);
      send_beat(1'b1, 8'hAC, 1'b0, 1'b0);
      send_beat(1'b1, 8'hFF, 1'b0, 1'b0);
      send_beat(1'b1, 8'h41, 1'b0, 1'b0);
      send_beat(1'b1, 8'h00, 1'b0, 1'b0);
      send_beat(1'b0, 8'hFF, 1'b1, 1'b0);
      drain_results();
      send_beat(1'b1, 8'hBF, 1'b0, 1'b0);
      send_beat(1'b1, 8'h80, 1'b0, 1'b0);
      send_beat(1'b1, 8'h80, 1'b0, 1'b0);
      send_beat(1'b0, 8'h5A, 1'b0, 1'b1);
      send_text("<t", 1'b1, 1'b1);
   endtask

   // tool-call marker ends all output; later beats are ignored
   task automatic test_tool_stop();
      send_beat(1'b1, 8'h7A, 1'b0, 1'b0);
      for (int i = 0; i < TOOL_LEN; i++)
         send_beat(1'b1, mark_byte(1'b0, i), i == TOOL_LEN - 1, 1'b0);
      send_beat(1'b1, 8'h71, 1'b1, 1'b1);
   endtask

   // one text byte with random chunk flags
   task automatic feed_random(logic [7:0] b);
      bit ce;
      bit ff;
      ce = ($urandom_range(0, 7) == 0);
      ff = ce ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 15) == 0);
      send_beat(1'b1, b, ce, ff);
   endtask

   task automatic random_fragment();
      bit reason;
      int kind;
      int n;
      reason = (split_mode == MODE_REASON);
      kind   = $urandom_range(0, 11);
      // tool-call markers end the stream, keep them rare
      if ((kind == 6 || kind == 7) && !reason && $urandom_range(0, 3) != 0) kind = 0;
      if (kind == 11 && $urandom_range(0, 2) != 0) kind = 1;
      case (kind)
         0, 1, 2, 3: begin
            repeat ($urandom_range(1, 4)) feed_random(8'($urandom_range(8'h20, 8'h7E)));
         end
         4, 5: begin
            n = $urandom_range(2, 4);
            if (n == 2) feed_random(8'($urandom_range(8'hC2, 8'hDF)));
            else if (n == 3) feed_random(8'($urandom_range(8'hE0, 8'hEF)));
            else feed_random(8'($urandom_range(8'hF0, 8'hF7)));
            repeat (n - 1) feed_random(8'($urandom_range(8'h80, 8'hBF)));
         end
         6, 7: begin
            for (int i = 0; i < mark_len(reason); i++) feed_random(mark_byte(reason, i));
         end
         8: begin
            n = $urandom_range(1, mark_len(reason) - 1);
            for (int i = 0; i < n; i++) feed_random(mark_byte(reason, i));
            feed_random(8'($urandom_range(0, 255)));
         end
         9: feed_random(8'($urandom_range(0, 255)));
         10: send_beat(1'b0, 8'($urandom_range(0, 255)), $urandom_range(0, 3) != 0,
                       1'($urandom_range(0, 1)));
         default: drain_results();
      endcase
   endtask

   task automatic test_random_streams();
      int goal;
      int phase;
      int frags;
      goal  = live_beats + RANDOM_BEATS;
      phase = 0;
      while (live_beats < goal) begin
         csr_write(phase == 0 ? 1'b1 : phase == 1 ? 1'b0 : 1'($urandom_range(0, 1)));
         frags = $urandom_range(10, 30);
         while (frags > 0 && live_beats < goal && split_mode != MODE_STOP) begin
            // no idling in the closing stretch
            if (live_beats >= goal - 30) gaps_on = 1'b0;
            random_fragment();
            frags--;
         end
         phase++;
      end
   endtask

   initial begin
      restart_stream(1'b0);
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reason_to_content();
      test_utf8_edges();
      test_tool_stop();
      test_random_streams();

      drain_results();
      repeat (SETTLE_CYC) @(posedge clock);
      if (fail_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

### marker_stream_splitter.f
src/mss_pkg.sv
src/mss_cell.sv
src/mss_hold_chain.sv
src/mss_ctrl.sv
src/marker_stream_splitter.sv
verif/marker_stream_splitter_tb.sv
